### hdl/assert_macros.svh
// Assertion macros shared by the normal CDF pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked check, disabled while the synchronous reset is asserted.
`define NCDF_ASSERT(lbl, c, r, prop, msg) \
  lbl: assert property (@(posedge c) disable iff (!(r)) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define NCDF_ASSERT_ALWAYS(lbl, c, prop, msg) \
  lbl: assert property (@(posedge c) (prop)) else $error(msg);
`endif

### hdl/ncdf_pkg.sv
// Shared constants and types for the normal CDF pipeline.
package ncdf_pkg;

  // Q30 fixed-point constants
  localparam logic [30:0] ONE  = 31'h4000_0000;
  localparam logic [30:0] HALF = 31'h2000_0000;
  localparam logic [27:0] GAMMA = 28'd248723596;
  localparam logic [28:0] INV_SQRT_2PI = 29'd428361012;

  typedef logic signed [31:0] coef_t;
  localparam coef_t POLY_COEF [5] = '{
    32'sd342933307, -32'sd382857446, 32'sd1912847369, -32'sd1955558716, 32'sd1428371292
  };

  localparam int RCP_STAGES = 31;
  localparam int EXP_TERMS  = 12;
  localparam int EXP_SQUARES = 5;
  localparam int POLY_STEPS = 6;

  typedef struct packed {
    logic        neg;
    logic [30:0] w;
  } rcp_side_t;

  typedef struct packed {
    logic        neg;
    logic [30:0] k;
  } exp_side_t;

endpackage

### hdl/normal_cdf_poly_approx.sv
// Top level: pipelined normal CDF, five-term polynomial approximation.
//
// Usage:
//   Drive in_x_value (signed Q3.12 at the default width) and raise start.
//   A transfer happens at every rising edge with start high and busy low.
//   busy is low at all times outside reset, so one argument may be sent
//   in every clock cycle, back to back.
//   Each result appears on out_probability (unsigned Q0.16) for exactly one
//   cycle with out_valid high, in input order. Each argument passes through
//   the chain of registered stages:
//     3 front-end stages (magnitude, products, D and w),
//     31 divider stages, one quotient bit each, for K = 1/(1 + gamma L),
//     24 Taylor stages (multiply, then rounded divide by k and subtract),
//     5 squaring stages, 1 density stage, 12 polynomial stages and 1
//     output stage for clamping, mirroring and saturation.
//   Throughput is one result per cycle. The receiver cannot stall: results
//   are not held, so it must take each one in the cycle it is shown.
//   Synchronous reset (rst_n low) clears every valid bit; items in flight are
//   dropped. busy stays high during reset and drops on the first edge after it.
module normal_cdf_poly_approx #(
  parameter int ARG_WIDTH  = 16,
  parameter int PROB_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [ARG_WIDTH-1:0] in_x_value,
  output logic                        out_valid,
  output logic [PROB_WIDTH-1:0]       out_probability
);
  import ncdf_pkg::*;
  `include "assert_macros.svh"

  logic busy_r;
  logic accept;

  // front end -> divider
  logic        fr_valid;
  logic [31:0] fr_d;
  rcp_side_t   fr_side;

  // divider -> exponential
  logic        rc_valid;
  logic [30:0] rc_k;
  rcp_side_t   rc_side;

  // exponential -> tail
  logic        ex_valid;
  logic [30:0] ex_e;
  exp_side_t   ex_side;

  // busy only covers reset; the pipeline never backs up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  ncdf_front #(
    .ARG_WIDTH (ARG_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_x      (in_x_value),
    .out_valid (fr_valid),
    .out_d     (fr_d),
    .out_side  (fr_side)
  );

  ncdf_recip u_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_d      (fr_d),
    .in_side   (fr_side),
    .out_valid (rc_valid),
    .out_k     (rc_k),
    .out_side  (rc_side)
  );

  ncdf_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rc_valid),
    .in_k      (rc_k),
    .in_side   (rc_side),
    .out_valid (ex_valid),
    .out_e     (ex_e),
    .out_side  (ex_side)
  );

  ncdf_tail #(
    .PROB_WIDTH (PROB_WIDTH)
  ) u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ex_valid),
    .in_e      (ex_e),
    .in_side   (ex_side),
    .out_valid (out_valid),
    .out_prob  (out_probability)
  );

  `NCDF_ASSERT_ALWAYS(a_busy_after_reset, clk, $past(rst_n) |-> !busy, "busy high outside reset")
  `NCDF_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid, "result strobe after reset")

endmodule

### hdl/ncdf_front.sv
// Front end: magnitude, Q28 argument, divisor D and exponent argument w.
module ncdf_front #(
  parameter int ARG_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic signed [ARG_WIDTH-1:0] in_x,
  output logic                        out_valid,
  output logic [31:0]                 out_d,
  output ncdf_pkg::rcp_side_t         out_side
);
  import ncdf_pkg::*;

  logic [ARG_WIDTH-1:0] raw;
  logic [ARG_WIDTH-1:0] mag;
  logic                 neg;
  logic [31:0]          l_nxt;

  logic        v1_r, v2_r, v3_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [31:0] l1_r;
  logic [59:0] gl2_r, gl2_nxt;
  logic [63:0] sq2_r, sq2_nxt;
  logic [31:0] d3_r, d3_nxt;
  logic [30:0] w3_r, w3_nxt;

  always_comb begin
    raw   = in_x;
    neg   = raw[ARG_WIDTH-1];
    mag   = neg ? (~raw + 1'b1) : raw;
    l_nxt = 32'(mag) << (32 - ARG_WIDTH);
  end

  assign gl2_nxt = 60'(GAMMA) * 60'(l1_r);
  assign sq2_nxt = 64'(l1_r) * 64'(l1_r);
  assign d3_nxt  = 32'(ONE) + 32'((gl2_r + 60'd134217728) >> 28);
  assign w3_nxt  = 31'((sq2_r + 64'h8000_0000) >> 32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    neg1_r <= neg;
    l1_r   <= l_nxt;
    neg2_r <= neg1_r;
    gl2_r  <= gl2_nxt;
    sq2_r  <= sq2_nxt;
    neg3_r <= neg2_r;
    d3_r   <= d3_nxt;
    w3_r   <= w3_nxt;
  end

  assign out_valid    = v3_r;
  assign out_d        = d3_r;
  assign out_side.neg = neg3_r;
  assign out_side.w   = w3_r;

endmodule

### hdl/ncdf_recip.sv
// Restoring divider, one quotient bit per stage: K = round(2^60 / D).
module ncdf_recip (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [31:0]         in_d,
  input  ncdf_pkg::rcp_side_t in_side,
  output logic                out_valid,
  output logic [30:0]         out_k,
  output ncdf_pkg::rcp_side_t out_side
);
  import ncdf_pkg::*;
  `include "assert_macros.svh"

  typedef struct packed {
    logic [31:0] d;
    logic [30:0] nl;
    logic [31:0] rem;
    logic [30:0] q;
    rcp_side_t   side;
  } rcp_stage_t;

  logic       v_r  [RCP_STAGES];
  rcp_stage_t st_r [RCP_STAGES];

  for (genvar g = 0; g < RCP_STAGES; g++) begin : g_stage
    logic       v_in;
    rcp_stage_t s_in;
    rcp_stage_t s_nxt;
    logic [32:0] rem2;
    logic        ge;

    if (g == 0) begin : g_first
      // dividend is 2^60 + D/2; its top part is 2^29, always below D
      always_comb begin
        v_in      = in_valid;
        s_in.d    = in_d;
        s_in.nl   = in_d[31:1];
        s_in.rem  = 32'h2000_0000;
        s_in.q    = '0;
        s_in.side = in_side;
      end
    end else begin : g_next
      always_comb begin
        v_in = v_r[g-1];
        s_in = st_r[g-1];
      end
    end

    always_comb begin
      rem2  = {s_in.rem, s_in.nl[RCP_STAGES-1-g]};
      ge    = rem2 >= {1'b0, s_in.d};
      s_nxt = s_in;
      s_nxt.rem = ge ? 32'(rem2 - {1'b0, s_in.d}) : rem2[31:0];
      s_nxt.q[RCP_STAGES-1-g] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      st_r[g] <= s_nxt;
    end
  end

  assign out_valid = v_r[RCP_STAGES-1];
  assign out_k     = st_r[RCP_STAGES-1].q;
  assign out_side  = st_r[RCP_STAGES-1].side;

  `NCDF_ASSERT(a_k_le_one, clk, rst_n, out_valid |-> (out_k <= ONE), "reciprocal above 1.0")

endmodule

### hdl/ncdf_exp.sv
// exp(-L^2/2): Horner Taylor series on w = L^2/64, then five squarings.
module ncdf_exp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [30:0]         in_k,
  input  ncdf_pkg::rcp_side_t in_side,
  output logic                out_valid,
  output logic [30:0]         out_e,
  output ncdf_pkg::exp_side_t out_side
);
  import ncdf_pkg::*;
  `include "assert_macros.svh"

  // product stage
  logic        va_r [EXP_TERMS];
  logic [61:0] pa_r [EXP_TERMS];
  logic [30:0] wa_r [EXP_TERMS];
  exp_side_t   sa_r [EXP_TERMS];
  // update stage
  logic        vb_r [EXP_TERMS];
  logic [30:0] rb_r [EXP_TERMS];
  logic [30:0] wb_r [EXP_TERMS];
  exp_side_t   sb_r [EXP_TERMS];
  // squaring stages
  logic        vs_r [EXP_SQUARES];
  logic [30:0] es_r [EXP_SQUARES];
  exp_side_t   ss_r [EXP_SQUARES];

  for (genvar g = 0; g < EXP_TERMS; g++) begin : g_term
    localparam int KV = EXP_TERMS - g;
    localparam logic [61:0] RBIAS = 62'(KV) << 29;
    // ceil(2^35 / k); floor(q * KRCP / 2^35) == floor(q / k) for q below 2^31
    localparam logic [35:0] KRCP = 36'(((64'd1 << 35) + 64'(KV) - 64'd1) / 64'(KV));

    logic        v_in;
    logic [30:0] r_in;
    logic [30:0] w_in;
    exp_side_t   s_in;
    logic [32:0] q1;
    logic [68:0] qm;
    logic [32:0] t;
    logic [30:0] r_nxt;

    if (g == 0) begin : g_first
      always_comb begin
        v_in     = in_valid;
        r_in     = ONE;
        w_in     = in_side.w;
        s_in.neg = in_side.neg;
        s_in.k   = in_k;
      end
    end else begin : g_next
      always_comb begin
        v_in = vb_r[g-1];
        r_in = rb_r[g-1];
        w_in = wb_r[g-1];
        s_in = sb_r[g-1];
      end
    end

    // rounded w*r / (k * 2^30), then 1 - t floored at zero
    always_comb begin
      q1    = 33'((pa_r[g] + RBIAS) >> 30);
      qm    = 69'(q1) * 69'(KRCP);
      t     = 33'(qm >> 35);
      r_nxt = (t >= 33'(ONE)) ? '0 : ONE - 31'(t);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[g] <= 1'b0;
        vb_r[g] <= 1'b0;
      end else begin
        va_r[g] <= v_in;
        vb_r[g] <= va_r[g];
      end
    end

    always_ff @(posedge clk) begin
      pa_r[g] <= 62'(w_in) * 62'(r_in);
      wa_r[g] <= w_in;
      sa_r[g] <= s_in;
      rb_r[g] <= r_nxt;
      wb_r[g] <= wa_r[g];
      sb_r[g] <= sa_r[g];
    end
  end

  for (genvar g = 0; g < EXP_SQUARES; g++) begin : g_sq
    logic        v_in;
    logic [30:0] e_in;
    exp_side_t   s_in;
    logic [61:0] sq;

    if (g == 0) begin : g_first
      always_comb begin
        v_in = vb_r[EXP_TERMS-1];
        e_in = rb_r[EXP_TERMS-1];
        s_in = sb_r[EXP_TERMS-1];
      end
    end else begin : g_next
      always_comb begin
        v_in = vs_r[g-1];
        e_in = es_r[g-1];
        s_in = ss_r[g-1];
      end
    end

    assign sq = 62'(e_in) * 62'(e_in);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[g] <= 1'b0;
      end else begin
        vs_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      es_r[g] <= 31'((sq + 62'(HALF)) >> 30);
      ss_r[g] <= s_in;
    end
  end

  assign out_valid = vs_r[EXP_SQUARES-1];
  assign out_e     = es_r[EXP_SQUARES-1];
  assign out_side  = ss_r[EXP_SQUARES-1];

  `NCDF_ASSERT(a_e_le_one, clk, rst_n, out_valid |-> (out_e <= ONE), "exponential above 1.0")

endmodule

### hdl/ncdf_tail.sv
// Density, polynomial in K, tail clamp, mirror and output scaling.
module ncdf_tail #(
  parameter int PROB_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [30:0]           in_e,
  input  ncdf_pkg::exp_side_t   in_side,
  output logic                  out_valid,
  output logic [PROB_WIDTH-1:0] out_prob
);
  import ncdf_pkg::*;

  localparam int RW = 32 + PROB_WIDTH;

  typedef struct packed {
    logic        neg;
    logic [30:0] k;
    logic [30:0] dens;
  } tl_side_t;

  localparam coef_t ADD_COEF [POLY_STEPS] = '{
    POLY_COEF[3], POLY_COEF[2], POLY_COEF[1], POLY_COEF[0], 32'sd0, 32'sd0
  };

  logic     v0_r;
  tl_side_t s0_r;

  logic                va_r  [POLY_STEPS];
  logic                nega_r[POLY_STEPS];
  logic [65:0]         m_r   [POLY_STEPS];
  tl_side_t            sa_r  [POLY_STEPS];
  logic                vb_r  [POLY_STEPS];
  logic signed [34:0]  pb_r  [POLY_STEPS];
  tl_side_t            sb_r  [POLY_STEPS];

  logic                  vo_r;
  logic [PROB_WIDTH-1:0] prob_r, prob_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_r.neg  <= in_side.neg;
    s0_r.k    <= in_side.k;
    s0_r.dens <= 31'((60'(INV_SQRT_2PI) * 60'(in_e) + 60'(HALF)) >> 30);
  end

  for (genvar j = 0; j < POLY_STEPS; j++) begin : g_step
    logic               v_in;
    logic signed [34:0] p_in;
    tl_side_t           s_in;
    logic [30:0]        b;
    logic [34:0]        mag;
    logic [34:0]        pr;
    logic signed [34:0] prs;
    logic signed [34:0] p_nxt;

    if (j == 0) begin : g_first
      always_comb begin
        v_in = v0_r;
        p_in = 35'(POLY_COEF[4]);
        s_in = s0_r;
      end
    end else begin : g_next
      always_comb begin
        v_in = vb_r[j-1];
        p_in = pb_r[j-1];
        s_in = sb_r[j-1];
      end
    end

    // last step multiplies by the density, the others by K
    if (j == POLY_STEPS - 1) begin : g_dens
      assign b = s_in.dens;
    end else begin : g_k
      assign b = s_in.k;
    end

    always_comb begin
      mag   = p_in[34] ? 35'(-p_in) : 35'(p_in);
      pr    = 35'((m_r[j] + 66'(HALF)) >> 30);
      prs   = signed'(pr);
      p_nxt = (nega_r[j] ? -prs : prs) + 35'(ADD_COEF[j]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[j] <= 1'b0;
        vb_r[j] <= 1'b0;
      end else begin
        va_r[j] <= v_in;
        vb_r[j] <= va_r[j];
      end
    end

    always_ff @(posedge clk) begin
      nega_r[j] <= p_in[34];
      m_r[j]    <= 66'(mag) * 66'(b);
      sa_r[j]   <= s_in;
      pb_r[j]   <= p_nxt;
      sb_r[j]   <= sa_r[j];
    end
  end

  logic signed [34:0] tail;
  logic [30:0]        tu;
  logic [30:0]        v;
  logic [RW-1:0]      rr;

  always_comb begin
    tail = pb_r[POLY_STEPS-1];
    if (tail[34]) begin
      tu = '0;
    end else if (tail > 35'(ONE)) begin
      tu = ONE;
    end else begin
      tu = 31'(tail);
    end
    v  = sb_r[POLY_STEPS-1].neg ? tu : ONE - tu;
    rr = ((RW'(v) << PROB_WIDTH) + RW'(HALF)) >> 30;
    prob_nxt = (|rr[RW-1:PROB_WIDTH]) ? '1 : rr[PROB_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= vb_r[POLY_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    prob_r <= prob_nxt;
  end

  assign out_valid = vo_r;
  assign out_prob  = prob_r;

endmodule
